>>> src/awp_pkg.sv
// Package for the three-channel angle-wrap PID core.
// Holds widths, angle constants, register codes and shared types.
// No dependencies.
package awp_pkg;

    localparam int CHANNELS_DEFAULT = 3;
    localparam int GAIN_SETS        = 3;
    localparam int PIPE_DEPTH       = 5;

    localparam int CHAN_W     = 2;
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 13;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int SUM_W      = 21;
    localparam int GAIN_W     = 16;
    localparam int GAINS_W    = 3 * GAIN_W;
    localparam int ILIM_W     = 20;
    localparam int DLIM_W     = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int HALF_TURN   = 2880;
    localparam int FULL_TURN   = 5760;
    localparam int WRAP_TURNS  = 12;
    localparam int WRAP_BIAS   = HALF_TURN + WRAP_TURNS * FULL_TURN;
    localparam int TURN_SHIFT  = 7;
    localparam int TURN_ODD    = FULL_TURN / (2 ** TURN_SHIFT);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (2 ** RECIP_SHIFT + TURN_ODD - 1) / TURN_ODD;

    localparam int Q_FRAC     = 8;
    localparam int ROUND_HALF = 2 ** (Q_FRAC - 1);
    localparam int P_KP_W     = ERR_W + GAIN_W + 1;
    localparam int P_KI_W     = SUM_W + GAIN_W + 1;
    localparam int P_KD_W     = DELTA_W + GAIN_W + 1;
    localparam int ACC_W      = P_KI_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_CH0         = 3'd0,
        REG_GAINS_CH1         = 3'd1,
        REG_GAINS_CH2         = 3'd2,
        REG_INTEGRAL_LIMIT    = 3'd3,
        REG_DRIVE_LIMIT_FIRST = 3'd4,
        REG_DRIVE_LIMIT_REST  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_SETS-1:0][GAINS_W-1:0] gains;
        logic [ILIM_W-1:0]                 integral_limit;
        logic [DLIM_W-1:0]                 drive_limit_first;
        logic [DLIM_W-1:0]                 drive_limit_rest;
    } cfg_t;

    typedef struct packed {
        logic              fire;
        logic [CHAN_W-1:0] channel;
        logic [ERR_W-1:0]  err;
    } integ_req_t;

endpackage

>>> src/awp_ifs.sv
// Valid/ready channel interfaces for the angle-wrap PID core.
// Request, response and register-write channels; uses awp_pkg.
interface awp_cmd_if;
    import awp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CHAN_W-1:0]         channel;
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [ANGLE_W-1:0] measured_angle;
    modport source (output valid, channel, target_angle, measured_angle, input ready);
    modport sink (input valid, channel, target_angle, measured_angle, output ready);
endinterface

interface awp_rsp_if;
    import awp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    modport source (output valid, drive, input ready);
    modport sink (input valid, drive, output ready);
endinterface

interface awp_cfg_if;
    import awp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/awp_cfg_regs.sv
// Configuration register file: gains, integral limit, drive limits.
// Uses awp_pkg and awp_cfg_if.
module awp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    awp_cfg_if.sink       cfg,
    output awp_pkg::cfg_t cfg_q
);
    import awp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAINS_CH0:         cfg_next.gains[0] = cfg.data[GAINS_W-1:0];
                REG_GAINS_CH1:         cfg_next.gains[1] = cfg.data[GAINS_W-1:0];
                REG_GAINS_CH2:         cfg_next.gains[2] = cfg.data[GAINS_W-1:0];
                REG_INTEGRAL_LIMIT:    cfg_next.integral_limit = cfg.data[ILIM_W-1:0];
                REG_DRIVE_LIMIT_FIRST: cfg_next.drive_limit_first = cfg.data[DLIM_W-1:0];
                REG_DRIVE_LIMIT_REST:  cfg_next.drive_limit_rest = cfg.data[DLIM_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gains             <= '0;
            cfg_reg.integral_limit    <= '1;
            cfg_reg.drive_limit_first <= '1;
            cfg_reg.drive_limit_rest  <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/awp_wrap.sv
// Angle error wrap: target minus measured, floor modulo into [-2880, 2879].
// Quotient by reciprocal multiply on the biased difference; uses awp_pkg.
module awp_wrap (
    input  logic signed [awp_pkg::ANGLE_W-1:0] target_angle,
    input  logic signed [awp_pkg::ANGLE_W-1:0] measured_angle,
    output logic signed [awp_pkg::ERR_W-1:0]   err
);
    import awp_pkg::*;

    localparam int DIFF_W = ANGLE_W + 1;
    localparam int Y_W    = 18;
    localparam int Z_W    = Y_W - TURN_SHIFT;
    localparam int R_W    = 11;
    localparam int MUL_W  = Z_W + R_W;
    localparam int Q_W    = 5;

    logic signed [DIFF_W-1:0] diff;
    logic signed [Y_W:0]      biased_s;
    logic [Y_W-1:0]           biased;
    logic [Z_W-1:0]           coarse;
    logic [MUL_W-1:0]         scaled;
    logic [Q_W-1:0]           turns;
    logic [Y_W-1:0]           rem;
    logic signed [ERR_W:0]    centered;

    always_comb
    begin
        diff     = $signed({target_angle[ANGLE_W-1], target_angle})
                 - $signed({measured_angle[ANGLE_W-1], measured_angle});
        biased_s = (Y_W+1)'(diff) + (Y_W+1)'(WRAP_BIAS);
        biased   = biased_s[Y_W-1:0];
        coarse   = biased[Y_W-1:TURN_SHIFT];
        scaled   = MUL_W'(coarse) * MUL_W'(RECIP);
        turns    = scaled[RECIP_SHIFT +: Q_W];
        rem      = biased - Y_W'(turns) * Y_W'(FULL_TURN);
        centered = $signed({1'b0, rem[ERR_W-1:0]}) - (ERR_W+1)'(HALF_TURN);
        err      = centered[ERR_W-1:0];
    end

endmodule

>>> src/awp_integ.sv
// Per-channel state: previous error and clamped error integral.
// Read and update in the same cycle; uses awp_pkg.
module awp_integ #(
    parameter int CHANNELS = awp_pkg::CHANNELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  awp_pkg::integ_req_t               req,
    input  logic [awp_pkg::ILIM_W-1:0]        integral_limit,
    output logic signed [awp_pkg::ERR_W-1:0]  prev_err,
    output logic signed [awp_pkg::SUM_W-1:0]  sum_next
);
    import awp_pkg::*;

    localparam int LIVE  = (CHANNELS < GAIN_SETS) ? CHANNELS : GAIN_SETS;
    localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;

    logic signed [ERR_W-1:0] last_error_reg [LIVE];
    logic signed [SUM_W-1:0] error_sum_reg [LIVE];

    logic [IDX_W-1:0]      idx;
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W:0] raw;
    logic signed [SUM_W:0] lim_hi;
    logic signed [SUM_W:0] lim_lo;
    logic signed [SUM_W:0] clamped;

    always_comb
    begin
        err      = $signed(req.err);
        idx      = (req.channel < CHAN_W'(LIVE)) ? req.channel[IDX_W-1:0] : '0;
        prev_err = last_error_reg[idx];
        raw      = (SUM_W+1)'(error_sum_reg[idx]) + (SUM_W+1)'(err);
        lim_hi   = $signed({2'b00, integral_limit});
        lim_lo   = -lim_hi;
        if (raw > lim_hi)
        begin
            clamped = lim_hi;
        end
        else if (raw < lim_lo)
        begin
            clamped = lim_lo;
        end
        else
        begin
            clamped = raw;
        end
        sum_next = clamped[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LIVE; k++)
            begin
                last_error_reg[k] <= '0;
                error_sum_reg[k]  <= '0;
            end
        end
        else if (req.fire)
        begin
            last_error_reg[idx] <= err;
            error_sum_reg[idx]  <= sum_next;
        end
    end

endmodule

>>> src/awp_prod.sv
// Gain products: kp*err, ki*integral, kd*error delta, Q8.8 gains.
// Uses awp_pkg.
module awp_prod (
    input  logic [awp_pkg::GAINS_W-1:0]        gains,
    input  logic signed [awp_pkg::ERR_W-1:0]   err,
    input  logic signed [awp_pkg::DELTA_W-1:0] delta,
    input  logic signed [awp_pkg::SUM_W-1:0]   sum,
    output logic signed [awp_pkg::P_KP_W-1:0]  p_kp,
    output logic signed [awp_pkg::P_KI_W-1:0]  p_ki,
    output logic signed [awp_pkg::P_KD_W-1:0]  p_kd
);
    import awp_pkg::*;

    logic signed [GAIN_W:0] kp;
    logic signed [GAIN_W:0] ki;
    logic signed [GAIN_W:0] kd;

    always_comb
    begin
        kp   = $signed({1'b0, gains[GAIN_W-1:0]});
        ki   = $signed({1'b0, gains[2*GAIN_W-1:GAIN_W]});
        kd   = $signed({1'b0, gains[3*GAIN_W-1:2*GAIN_W]});
        p_kp = P_KP_W'(kp) * P_KP_W'(err);
        p_ki = P_KI_W'(ki) * P_KI_W'(sum);
        p_kd = P_KD_W'(kd) * P_KD_W'(delta);
    end

endmodule

>>> src/awp_sat.sv
// Drive output: sum of products, round half up from Q8.8, symmetric clamp.
// Uses awp_pkg.
module awp_sat (
    input  logic signed [awp_pkg::P_KP_W-1:0]  p_kp,
    input  logic signed [awp_pkg::P_KI_W-1:0]  p_ki,
    input  logic signed [awp_pkg::P_KD_W-1:0]  p_kd,
    input  logic [awp_pkg::DLIM_W-1:0]         drive_limit,
    output logic signed [awp_pkg::DRIVE_W-1:0] drive
);
    import awp_pkg::*;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lim_lo;
    logic signed [ACC_W-1:0] clamped;

    always_comb
    begin
        acc    = ACC_W'(p_kp) + ACC_W'(p_ki) + ACC_W'(p_kd) + ACC_W'(ROUND_HALF);
        scaled = acc >>> Q_FRAC;
        lim_hi = $signed({{(ACC_W-DLIM_W){1'b0}}, drive_limit});
        lim_lo = -lim_hi;
        if (scaled > lim_hi)
        begin
            clamped = lim_hi;
        end
        else if (scaled < lim_lo)
        begin
            clamped = lim_lo;
        end
        else
        begin
            clamped = scaled;
        end
        drive = clamped[DRIVE_W-1:0];
    end

endmodule

>>> src/angle_wrap_pid_three_channel_core.sv
// Top level of the three-channel angle-wrap PID core: five-stage pipeline.
// Uses awp_pkg, awp_ifs, awp_cfg_regs, awp_wrap, awp_integ, awp_prod, awp_sat.
//
//  channel | dir | payload                                  | handshake
//  cmd     | in  | channel, target_angle, measured_angle    | valid/ready
//  rsp     | out | drive                                    | valid/ready
//  cfg     | in  | index, data                              | valid/ready (ready always high)
//
// One request per cycle unless a stalled response has filled the pipeline.
// Stages: input register, wrap, state update, gain products, round and clamp.
// Channel state is read and written at one stage, so back-to-back requests on
// one channel see each other's updates.
// Each stage advances when the next one is free; a stalled response holds only the
// stages behind it that are full. Reset clears valids, state, gains; limits all ones.
module angle_wrap_pid_three_channel_core #(
    parameter int CHANNELS = awp_pkg::CHANNELS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    awp_cmd_if.sink    cmd,
    awp_rsp_if.source  rsp,
    awp_cfg_if.sink    cfg
);
    import awp_pkg::*;

    localparam int LIVE = (CHANNELS < GAIN_SETS) ? CHANNELS : GAIN_SETS;

    cfg_t                    cfg_q;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   valid_next;
    logic [PIPE_DEPTH-1:0]   adv;
    logic [PIPE_DEPTH-1:0]   load;

    logic [CHAN_W-1:0]         s0_channel_reg;
    logic signed [ANGLE_W-1:0] s0_target_reg;
    logic signed [ANGLE_W-1:0] s0_measured_reg;

    logic                      s1_ok_reg;
    logic [CHAN_W-1:0]         s1_channel_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [ERR_W-1:0]   err_next;

    logic                      s2_ok_reg;
    logic [CHAN_W-1:0]         s2_channel_reg;
    logic signed [ERR_W-1:0]   s2_err_reg;
    logic signed [DELTA_W-1:0] s2_delta_reg;
    logic signed [SUM_W-1:0]   s2_sum_reg;
    integ_req_t                integ_req;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [DELTA_W-1:0] delta_next;

    logic                      s3_ok_reg;
    logic                      s3_first_reg;
    logic signed [P_KP_W-1:0]  s3_p_kp_reg;
    logic signed [P_KI_W-1:0]  s3_p_ki_reg;
    logic signed [P_KD_W-1:0]  s3_p_kd_reg;
    logic [CHAN_W-1:0]         gain_sel;
    logic signed [P_KP_W-1:0]  p_kp_next;
    logic signed [P_KI_W-1:0]  p_ki_next;
    logic signed [P_KD_W-1:0]  p_kd_next;

    logic signed [DRIVE_W-1:0] s4_drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;

    awp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // advance chain, back to front
    always_comb
    begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || rsp.ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? cmd.valid : valid_reg[0];
        load[0]       = adv[0] && cmd.valid;
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
            load[k]       = adv[k] && valid_reg[k-1];
        end
    end

    assign cmd.ready = adv[0];
    assign rsp.valid = valid_reg[PIPE_DEPTH-1];
    assign rsp.drive = s4_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    awp_wrap u_wrap (
        .target_angle   (s0_target_reg),
        .measured_angle (s0_measured_reg),
        .err            (err_next)
    );

    assign integ_req.fire    = load[2] && s1_ok_reg;
    assign integ_req.channel = s1_channel_reg;
    assign integ_req.err     = s1_err_reg;

    awp_integ #(
        .CHANNELS (CHANNELS)
    ) u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (integ_req),
        .integral_limit (cfg_q.integral_limit),
        .prev_err       (prev_err),
        .sum_next       (sum_next)
    );

    assign delta_next = DELTA_W'(s1_err_reg) - DELTA_W'(prev_err);
    assign gain_sel   = s2_ok_reg ? s2_channel_reg : '0;

    awp_prod u_prod (
        .gains (cfg_q.gains[gain_sel]),
        .err   (s2_err_reg),
        .delta (s2_delta_reg),
        .sum   (s2_sum_reg),
        .p_kp  (p_kp_next),
        .p_ki  (p_ki_next),
        .p_kd  (p_kd_next)
    );

    awp_sat u_sat (
        .p_kp        (s3_p_kp_reg),
        .p_ki        (s3_p_ki_reg),
        .p_kd        (s3_p_kd_reg),
        .drive_limit (s3_first_reg ? cfg_q.drive_limit_first : cfg_q.drive_limit_rest),
        .drive       (drive_next)
    );

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_channel_reg  <= cmd.channel;
            s0_target_reg   <= cmd.target_angle;
            s0_measured_reg <= cmd.measured_angle;
        end
        if (load[1])
        begin
            s1_ok_reg      <= (s0_channel_reg < CHAN_W'(LIVE));
            s1_channel_reg <= s0_channel_reg;
            s1_err_reg     <= err_next;
        end
        if (load[2])
        begin
            s2_ok_reg      <= s1_ok_reg;
            s2_channel_reg <= s1_channel_reg;
            s2_err_reg     <= s1_err_reg;
            s2_delta_reg   <= delta_next;
            s2_sum_reg     <= sum_next;
        end
        if (load[3])
        begin
            s3_ok_reg    <= s2_ok_reg;
            s3_first_reg <= (s2_channel_reg == '0);
            s3_p_kp_reg  <= p_kp_next;
            s3_p_ki_reg  <= p_ki_next;
            s3_p_kd_reg  <= p_kd_next;
        end
        if (load[4])
        begin
            s4_drive_reg <= s3_ok_reg ? drive_next : '0;
        end
    end

endmodule

>>> src/awp_checker.sv
// Port-level checks for the angle-wrap PID core, bound to the top level.
// Uses awp_pkg; watches the cmd and rsp channels only.
module awp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [awp_pkg::DRIVE_W-1:0] rsp_drive
);
    import awp_pkg::*;

    logic [2:0] outstanding_reg;
    logic [2:0] outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (cmd_valid && cmd_ready)
        begin
            outstanding_next = outstanding_next + 3'd1;
        end
        if (rsp_valid && rsp_ready)
        begin
            outstanding_next = outstanding_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
        else $error("stalled response changed or dropped");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 3'd0)
        else $error("response without a pending request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_drive != 16'sh8000)
        else $error("drive outside symmetric clamp");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("request stalled with empty output stage");

endmodule

bind angle_wrap_pid_three_channel_core awp_checker u_awp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_drive (rsp.drive)
);

>>> verif/angle_wrap_pid_three_channel_core_tb.sv
// Testbench for angle_wrap_pid_three_channel_core: drives angle requests and register
// writes, predicts each drive with a cycle-free copy of the PID math, checks every response.
// Depends on awp_pkg, the awp_ifs interfaces and the core itself.
module angle_wrap_pid_three_channel_core_tb;
    import awp_pkg::*;

    localparam logic [CHAN_W-1:0]    CH_YAW     = 2'd0;
    localparam logic [CHAN_W-1:0]    CH_PITCH   = 2'd1;
    localparam logic [CHAN_W-1:0]    CH_ROLL    = 2'd2;
    localparam logic [CHAN_W-1:0]    CH_INVALID = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_SETS  = 8;
    localparam int ITEMS_PER_SET = 85;

    logic clk;
    logic rst_n;

    awp_cmd_if cmd_bus ();
    awp_rsp_if rsp_bus ();
    awp_cfg_if cfg_bus ();

    angle_wrap_pid_three_channel_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    longint            axis_prev_err [3];
    longint            axis_err_sum  [3];
    logic [GAINS_W-1:0] axis_gains   [3];
    longint            sum_limit;
    longint            yaw_drive_limit;
    longint            other_drive_limit;

    logic signed [DRIVE_W-1:0] drive_expected_q [$];
    logic signed [DRIVE_W-1:0] want_drive;
    int fail_count;
    bit cmd_gaps;
    bit rsp_stalls;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] compute_drive(logic [CHAN_W-1:0] ch,
                                                                logic signed [ANGLE_W-1:0] tgt,
                                                                logic signed [ANGLE_W-1:0] meas);
        longint diff;
        longint err;
        longint sum;
        longint acc;
        longint drv;
        longint kp;
        longint ki;
        longint kd;
        if (ch > CH_ROLL)
            return '0;
        diff = longint'(tgt) - longint'(meas);
        err = (diff + HALF_TURN) % FULL_TURN;
        if (err < 0)
            err += FULL_TURN;
        err -= HALF_TURN;
        sum = clamp_sym(axis_err_sum[ch] + err, sum_limit);
        kp = longint'(axis_gains[ch][15:0]);
        ki = longint'(axis_gains[ch][31:16]);
        kd = longint'(axis_gains[ch][47:32]);
        acc = kp * err + ki * sum + kd * (err - axis_prev_err[ch]);
        drv = (acc + ROUND_HALF) >>> Q_FRAC;
        drv = clamp_sym(drv, (ch == CH_YAW) ? yaw_drive_limit : other_drive_limit);
        axis_prev_err[ch] = err;
        axis_err_sum[ch] = sum;
        return drv[DRIVE_W-1:0];
    endfunction

    function automatic logic [GAINS_W-1:0] pack_gains(logic [15:0] kp, logic [15:0] ki,
                                                      logic [15:0] kd);
        return {kd, ki, kp};
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 1023));
            3: return 16'($urandom_range(0, 63));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ILIM_W-1:0] pick_limit(logic [ILIM_W-1:0] top);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return top;
            2: return ILIM_W'($urandom_range(0, 64));
            default: return ILIM_W'($urandom) & top;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (drive_expected_q.size() == 0)
            begin
                $error("drive: expected none, actual %0d", rsp_bus.drive);
                fail_count++;
            end
            else
            begin
                want_drive = drive_expected_q.pop_front();
                if (rsp_bus.drive !== want_drive)
                begin
                    $error("drive: expected %0d, actual %0d", want_drive, rsp_bus.drive);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                rsp_bus.ready <= 1'b1;
            end
            else if (rsp_stalls && $urandom_range(0, 7) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic [CHAN_W-1:0] ch, input logic signed [ANGLE_W-1:0] tgt,
                            input logic signed [ANGLE_W-1:0] meas);
        if (cmd_gaps && $urandom_range(0, 5) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.channel        <= ch;
        cmd_bus.target_angle   <= tgt;
        cmd_bus.measured_angle <= meas;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        drive_expected_q.push_back(compute_drive(ch, tgt, meas));
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (drive_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_GAINS_CH0:         axis_gains[0] = value;
            REG_GAINS_CH1:         axis_gains[1] = value;
            REG_GAINS_CH2:         axis_gains[2] = value;
            REG_INTEGRAL_LIMIT:    sum_limit = longint'(value[ILIM_W-1:0]);
            REG_DRIVE_LIMIT_FIRST: yaw_drive_limit = longint'(value[DLIM_W-1:0]);
            REG_DRIVE_LIMIT_REST:  other_drive_limit = longint'(value[DLIM_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [GAINS_W-1:0] g0, input logic [GAINS_W-1:0] g1,
                                input logic [GAINS_W-1:0] g2, input logic [ILIM_W-1:0] ilim,
                                input logic [DLIM_W-1:0] dlim0, input logic [DLIM_W-1:0] dlimr,
                                input bit with_unmapped);
        wait_drained();
        write_reg(REG_GAINS_CH0, g0);
        write_reg(REG_GAINS_CH1, g1);
        write_reg(REG_GAINS_CH2, g2);
        write_reg(REG_INTEGRAL_LIMIT,
                  CFG_DATA_W'({$urandom, $urandom}) & ~CFG_DATA_W'(2**ILIM_W - 1)
                  | CFG_DATA_W'(ilim));
        write_reg(REG_DRIVE_LIMIT_FIRST, CFG_DATA_W'(dlim0));
        write_reg(REG_DRIVE_LIMIT_REST, CFG_DATA_W'(dlimr));
        if (with_unmapped)
        begin
            write_reg(REG_UNMAPPED_LO, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_UNMAPPED_HI, CFG_DATA_W'({$urandom, $urandom}));
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_random_item();
        logic [CHAN_W-1:0]         ch;
        logic signed [ANGLE_W-1:0] tgt;
        logic signed [ANGLE_W-1:0] meas;
        int base;
        ch = ($urandom_range(0, 15) == 0) ? CH_INVALID : CHAN_W'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:
            begin
                tgt  = ANGLE_W'($urandom);
                meas = ANGLE_W'($urandom);
            end
            1:
            begin
                meas = ANGLE_W'($urandom);
                tgt  = ANGLE_W'(int'(meas) + int'($urandom_range(0, 400)) - 200);
            end
            2:
            begin
                base = int'($urandom_range(0, 32000)) - 16000;
                meas = ANGLE_W'(base);
                tgt  = ANGLE_W'(base + (int'($urandom_range(0, 4)) - 2) * FULL_TURN
                                - HALF_TURN + int'($urandom_range(0, 2)) - 1);
            end
            default:
            begin
                tgt  = ANGLE_W'(int'($urandom_range(0, 4000)) - 2000);
                meas = ANGLE_W'(int'($urandom_range(0, 4000)) - 2000);
            end
        endcase
        send_cmd(ch, tgt, meas);
    endtask

    task automatic test_reset_defaults();
        send_cmd(CH_YAW, 16'sd1000, -16'sd500);
        send_cmd(CH_PITCH, -16'sd2000, 16'sd700);
        send_cmd(CH_ROLL, 16'sd32767, -16'sd32768);
    endtask

    task automatic test_rounding();
        program_regs('0, pack_gains(16'd128, 16'd0, 16'd0), '0, 20'hFFFFF, 15'h7FFF,
                     15'h7FFF, 1'b0);
        send_cmd(CH_PITCH, 16'sd1, 16'sd0);
        send_cmd(CH_PITCH, -16'sd1, 16'sd0);
        send_cmd(CH_PITCH, 16'sd3, 16'sd0);
        send_cmd(CH_PITCH, -16'sd3, 16'sd0);
    endtask

    task automatic test_angle_wrap();
        program_regs(pack_gains(16'd256, 16'd0, 16'd0), '0, '0, 20'hFFFFF, 15'h7FFF,
                     15'h7FFF, 1'b0);
        send_cmd(CH_YAW, -16'sd2880, 16'sd0);
        send_cmd(CH_YAW, 16'sd2880, 16'sd0);
        send_cmd(CH_YAW, 16'sd2879, 16'sd0);
        send_cmd(CH_YAW, -16'sd2881, 16'sd0);
        send_cmd(CH_YAW, 16'sd8640, 16'sd0);
        send_cmd(CH_YAW, 16'sd0, 16'sd8640);
        send_cmd(CH_YAW, 16'sd32767, -16'sd32768);
        send_cmd(CH_YAW, -16'sd32768, 16'sd32767);
        send_cmd(CH_YAW, 16'sd0, 16'sd0);
    endtask

    task automatic test_channel_out_of_range();
        program_regs(pack_gains(16'd300, 16'd40, 16'd900), pack_gains(16'd77, 16'd5, 16'd0),
                     pack_gains(16'd1, 16'd2, 16'd3), 20'd5000, 15'd20000, 15'd9000, 1'b0);
        send_cmd(CH_YAW, 16'sd100, 16'sd0);
        send_cmd(CH_INVALID, 16'sd2000, -16'sd2000);
        send_cmd(CH_YAW, 16'sd150, 16'sd0);
    endtask

    task automatic test_limits();
        program_regs({3{16'hFFFF}}, {3{16'hFFFF}}, pack_gains(16'd0, 16'd256, 16'd0), 20'd0,
                     15'd0, 15'h7FFF, 1'b1);
        send_cmd(CH_YAW, 16'sd2879, 16'sd0);
        send_cmd(CH_PITCH, -16'sd2880, 16'sd0);
        send_cmd(CH_PITCH, 16'sd2879, 16'sd0);
        program_regs({3{16'hFFFF}}, {3{16'hFFFF}}, pack_gains(16'd0, 16'd256, 16'd0),
                     20'hFFFFF, 15'h7FFF, 15'h7FFF, 1'b0);
        send_cmd(CH_ROLL, 16'sd2879, 16'sd0);
        send_cmd(CH_ROLL, 16'sd2879, 16'sd0);
        send_cmd(CH_ROLL, 16'sd2879, 16'sd0);
        program_regs({3{16'hFFFF}}, {3{16'hFFFF}}, pack_gains(16'd0, 16'd256, 16'd0), 20'd100,
                     15'h7FFF, 15'h7FFF, 1'b0);
        send_cmd(CH_ROLL, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_traffic();
        cmd_gaps   = 1'b1;
        rsp_stalls = 1'b1;
        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            if (set == 0)
                program_regs({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 20'hFFFFF,
                             15'h7FFF, 15'h7FFF, 1'b1);
            else if (set == 1)
                program_regs('0, '0, '0, '0, '0, '0, 1'b1);
            else
                program_regs(pack_gains(pick_gain(), pick_gain(), pick_gain()),
                             pack_gains(pick_gain(), pick_gain(), pick_gain()),
                             pack_gains(pick_gain(), pick_gain(), pick_gain()),
                             pick_limit(20'hFFFFF), DLIM_W'(pick_limit(20'h07FFF)),
                             DLIM_W'(pick_limit(20'h07FFF)), 1'($urandom_range(0, 1)));
            repeat (ITEMS_PER_SET) send_random_item();
        end
    endtask

    task automatic test_response_backpressure();
        program_regs(pack_gains(16'd512, 16'd3, 16'd200), pack_gains(16'd90, 16'd1, 16'd4000),
                     pack_gains(16'd2000, 16'd0, 16'd10), 20'd30000, 15'd12000, 15'd25000,
                     1'b0);
        cmd_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random_item();
    endtask

    task automatic test_steady_stream();
        program_regs(pack_gains(pick_gain(), pick_gain(), pick_gain()),
                     pack_gains(pick_gain(), pick_gain(), pick_gain()),
                     pack_gains(pick_gain(), pick_gain(), pick_gain()),
                     20'($urandom), 15'($urandom), 15'($urandom), 1'b0);
        cmd_gaps   = 1'b0;
        rsp_stalls = 1'b0;
        repeat (60) send_random_item();
    endtask

    initial
    begin
        fail_count = 0;
        cmd_gaps   = 1'b0;
        rsp_stalls = 1'b0;
        hold_req   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            axis_prev_err[k] = 0;
            axis_err_sum[k]  = 0;
            axis_gains[k]    = '0;
        end
        sum_limit         = 1048575;
        yaw_drive_limit   = 32767;
        other_drive_limit = 32767;
        rst_n                  <= 1'b0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.channel        <= '0;
        cmd_bus.target_angle   <= '0;
        cmd_bus.measured_angle <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= '0;
        cfg_bus.data           <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_rounding();
        test_angle_wrap();
        test_channel_out_of_range();
        test_limits();
        test_random_traffic();
        test_response_backpressure();
        test_steady_stream();

        wait_drained();
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
